// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; they compile to nothing under SYNTH.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Check a property on every rising edge, held off while reset is asserted.
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("property check failed");

// Check that cons holds whenever ante holds in the same cycle.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ----- src/rti_pkg.sv -----
// ----------------------------------------------------------------------------
// rti_pkg
// Types and constants shared by the RGB to I420 converter modules.
// ----------------------------------------------------------------------------
package rti_pkg;

    // Field widths
    localparam int BYTE_W     = 8;
    localparam int ADDR_W     = 24;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int MAX_RES    = 3;
    localparam int CNT_W      = 2;
    localparam int SUM_W      = 16;

    // Source formats
    typedef enum logic [1:0] {
        FMT_BGR24  = 2'd0,
        FMT_BGRX32 = 2'd1,
        FMT_YUY2   = 2'd2,
        FMT_RSVD   = 2'd3
    } t_format;

    // Destination planes
    typedef enum logic [1:0] {
        PLANE_Y = 2'd0,
        PLANE_U = 2'd1,
        PLANE_V = 2'd2
    } t_plane;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FORMAT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

    // Reset picture size
    localparam int RST_PICTURE_WIDTH  = 640;
    localparam int RST_PICTURE_HEIGHT = 480;

    // BT.601 integer coefficients (magnitudes, signs applied in the datapath)
    localparam logic [SUM_W-1:0] C_YR  = 16'd66;
    localparam logic [SUM_W-1:0] C_YG  = 16'd129;
    localparam logic [SUM_W-1:0] C_YB  = 16'd25;
    localparam logic [SUM_W-1:0] C_UR  = 16'd38;
    localparam logic [SUM_W-1:0] C_UG  = 16'd74;
    localparam logic [SUM_W-1:0] C_UB  = 16'd112;
    localparam logic [SUM_W-1:0] C_VR  = 16'd112;
    localparam logic [SUM_W-1:0] C_VG  = 16'd94;
    localparam logic [SUM_W-1:0] C_VB  = 16'd18;
    localparam logic [SUM_W-1:0] C_RND = 16'd128;
    // Chroma offset of 128 applied before the shift by 8 (128 << 8)
    localparam logic [SUM_W-1:0] C_CBIAS = 16'h8000;
    localparam logic [BYTE_W-1:0] Y_OFFSET = 8'd16;

    // One plane write
    typedef struct packed {
        t_plane              plane;
        logic [ADDR_W-1:0]   addr;
        logic [BYTE_W-1:0]   value;
    } t_result;

    // All writes caused by one input item
    typedef struct packed {
        t_result [MAX_RES-1:0] res;
        logic [CNT_W-1:0]      cnt;
        logic                  eop;
    } t_bundle;

endpackage

// ----- src/rti_position.sv -----
// ----------------------------------------------------------------------------
// rti_position
// Column and source row counters of the next input item.
// ----------------------------------------------------------------------------
module rti_position
    import rti_pkg::*;
#(
    parameter int CW = 12,
    parameter int RW = 12,
    parameter int WW = 13,
    parameter int HW = 13
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_restart,
    input  logic          i_advance,
    input  t_format       i_fmt,
    input  logic [WW-1:0] i_width,
    input  logic [HW-1:0] i_height,
    output logic [CW-1:0] o_col,
    output logic [RW-1:0] o_row,
    output logic          o_eop
);

    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic [CW-1:0] n_col;
    logic [RW-1:0] n_row;
    logic [WW-1:0] col_step;
    logic          row_end;
    logic          pic_end;

    always_comb begin
        col_step = WW'(r_col) + ((i_fmt == FMT_YUY2) ? WW'(2) : WW'(1));
        row_end  = (col_step >= i_width);
        pic_end  = (HW'(r_row) == (i_height - HW'(1)));
        n_col    = row_end ? '0 : CW'(col_step);
        n_row    = r_row;
        if (row_end) begin
            n_row = pic_end ? '0 : RW'(HW'(r_row) + HW'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_advance) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    assign o_col = r_col;
    assign o_row = r_row;
    assign o_eop = row_end && pic_end;

endmodule

// ----- src/rti_calc.sv -----
// ----------------------------------------------------------------------------
// rti_calc
// Color conversion and plane addressing for one item, combinational.
// ----------------------------------------------------------------------------
module rti_calc
    import rti_pkg::*;
#(
    parameter int CW = 12,
    parameter int RW = 12,
    parameter int WW = 13,
    parameter int HW = 13
) (
    input  t_format           i_fmt,
    input  logic [WW-1:0]     i_width,
    input  logic [HW-1:0]     i_height,
    input  logic [4*BYTE_W-1:0] i_data,
    input  logic [CW-1:0]     i_col,
    input  logic [RW-1:0]     i_row,
    input  logic              i_eop,
    output t_bundle           o_bundle
);

    logic [BYTE_W-1:0] b0, b1, b2, b3;
    logic [SUM_W-1:0]  y_sum, u_sum, v_sum;
    logic [BYTE_W-1:0] y_val;
    logic [RW-1:0]     orow;
    logic [ADDR_W-1:0] luma_addr;
    logic [ADDR_W-1:0] chroma_addr;
    t_plane            c_plane;

    always_comb begin
        b0 = i_data[0*BYTE_W +: BYTE_W];
        b1 = i_data[1*BYTE_W +: BYTE_W];
        b2 = i_data[2*BYTE_W +: BYTE_W];
        b3 = i_data[3*BYTE_W +: BYTE_W];

        // RGB modes: b0 blue, b1 green, b2 red
        y_sum = C_YR * SUM_W'(b2) + C_YG * SUM_W'(b1) + C_YB * SUM_W'(b0) + C_RND;
        u_sum = C_UB * SUM_W'(b0) + C_RND + C_CBIAS
              - C_UR * SUM_W'(b2) - C_UG * SUM_W'(b1);
        v_sum = C_VR * SUM_W'(b2) + C_RND + C_CBIAS
              - C_VG * SUM_W'(b1) - C_VB * SUM_W'(b0);
        y_val = y_sum[SUM_W-1 -: BYTE_W] + Y_OFFSET;

        // Flip rows in the RGB modes only
        if (i_fmt == FMT_YUY2) begin
            orow = i_row;
        end else begin
            orow = RW'(i_height - HW'(1) - HW'(i_row));
        end

        luma_addr   = ADDR_W'(orow) * ADDR_W'(i_width) + ADDR_W'(i_col);
        chroma_addr = ADDR_W'(orow >> 1) * ADDR_W'(i_width >> 1) + ADDR_W'(i_col >> 1);
        c_plane     = orow[0] ? PLANE_V : PLANE_U;

        o_bundle     = '0;
        o_bundle.eop = i_eop;
        if (i_fmt == FMT_YUY2) begin
            o_bundle.res[0] = '{plane: PLANE_Y, addr: luma_addr, value: b0};
            o_bundle.res[1] = '{plane: PLANE_Y, addr: luma_addr + ADDR_W'(1), value: b2};
            o_bundle.res[2] = '{plane: c_plane, addr: chroma_addr,
                                value: orow[0] ? b3 : b1};
            o_bundle.cnt    = CNT_W'(3);
        end else begin
            o_bundle.res[0] = '{plane: PLANE_Y, addr: luma_addr, value: y_val};
            o_bundle.res[1] = '{plane: c_plane, addr: chroma_addr,
                                value: orow[0] ? v_sum[SUM_W-1 -: BYTE_W]
                                               : u_sum[SUM_W-1 -: BYTE_W]};
            // Chroma only at even columns
            o_bundle.cnt    = i_col[0] ? CNT_W'(1) : CNT_W'(2);
        end
    end

endmodule

// ----- src/rti_emit.sv -----
// ----------------------------------------------------------------------------
// rti_emit
// Result register; hands out the writes of one item, one per transfer.
// ----------------------------------------------------------------------------
module rti_emit
    import rti_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_bundle i_bundle,
    output logic    o_ready,
    input  logic    i_m_tready,
    output logic    o_valid,
    output t_result o_res,
    output logic    o_last,
    output logic    o_eop
);

    t_bundle          r_bundle;
    logic             r_valid;
    logic [CNT_W-1:0] r_idx;
    logic             n_valid;
    logic [CNT_W-1:0] n_idx;
    logic             fire;
    logic             is_last;

    always_comb begin
        fire    = r_valid && i_m_tready;
        is_last = (r_idx == r_bundle.cnt - CNT_W'(1));
        o_ready = !r_valid || (fire && is_last);
        n_valid = r_valid;
        n_idx   = r_idx;
        if (i_load && o_ready) begin
            n_valid = 1'b1;
            n_idx   = '0;
        end else if (fire) begin
            if (is_last) begin
                n_valid = 1'b0;
            end else begin
                n_idx = r_idx + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_valid <= n_valid;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_ready) begin
            r_bundle <= i_bundle;
        end
    end

    always_comb begin
        case (r_idx)
            2'd0:    o_res = r_bundle.res[0];
            2'd1:    o_res = r_bundle.res[1];
            default: o_res = r_bundle.res[2];
        endcase
    end

    assign o_valid = r_valid;
    assign o_last  = is_last;
    assign o_eop   = r_bundle.eop;

endmodule

// ----- src/rgb_to_i420_converter.sv -----
// ----------------------------------------------------------------------------
// rgb_to_i420_converter
// Packed BGR24 / BGRX32 / YUY2 stream to planar I420 plane writes (BT.601).
// ----------------------------------------------------------------------------
//  Channel   Dir  Handshake              Carries
//  s_axis    in   i_s_tvalid/o_s_tready  one pixel (BGR modes) or pixel pair
//  m_axis    out  o_m_tvalid/i_m_tready  one plane write: address, value,
//                                        plane and end-of-picture in tuser
//  cfg       in   i_cfg_valid/o_cfg_ready register index and write data
//
//  An item waits in the input register and then moves to the result register,
//  which offers its writes on m_axis, one write per transfer.
//  The single result port sets the rate, held by output stalls: one write
//  per odd-column RGB pixel, two per even-column RGB pixel, three per YUY2 pair.
//  Reset is synchronous, active low: formats and sizes return to defaults,
//  the position returns to the first pixel; there is no clearing pass.
//  A stalled output holds the result register; the input register still
//  takes one more item behind it before o_s_tready drops.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rgb_to_i420_converter
    import rti_pkg::*;
#(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Stream in
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // [7:0] first_byte, [15:8] second_byte, [23:16] third_byte, [31:24] fourth_byte
    input  logic [4*BYTE_W-1:0]   i_s_tdata,
    // Stream out
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // [23:0] plane_address, [31:24] sample_value
    output logic [ADDR_W+BYTE_W-1:0] o_m_tdata,
    // [1:0] plane, [2] end_of_picture
    output logic [2:0]            o_m_tuser,
    output logic                  o_m_tlast,
    // Configuration writes
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // Position and size widths
    localparam int CW = (MAX_WIDTH  > 2) ? $clog2(MAX_WIDTH)  : 1;
    localparam int RW = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);

    // Effective reset sizes: clamp, force even, at least 2
    localparam int RW0   = (RST_PICTURE_WIDTH  > MAX_WIDTH)  ? MAX_WIDTH  : RST_PICTURE_WIDTH;
    localparam int RH0   = (RST_PICTURE_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RST_PICTURE_HEIGHT;
    localparam int RST_W = ((RW0 / 2) * 2 < 2) ? 2 : (RW0 / 2) * 2;
    localparam int RST_H = ((RH0 / 2) * 2 < 2) ? 2 : (RH0 / 2) * 2;

    // ---------------- configuration ----------------
    t_format          r_fmt;
    logic [WW-1:0]    r_width;
    logic [HW-1:0]    r_height;
    logic             cfg_fire;
    logic             cfg_restart;
    logic [CFG_DATA_W:0] w_clamp, h_clamp;

    assign o_cfg_ready = 1'b1;
    assign cfg_fire    = i_cfg_valid && o_cfg_ready;

    // Clamp to the maximum, drop bit 0, raise to at least 2
    always_comb begin
        w_clamp = ({1'b0, i_cfg_data} > (CFG_DATA_W+1)'(MAX_WIDTH))
                ? (CFG_DATA_W+1)'(MAX_WIDTH) : {1'b0, i_cfg_data};
        w_clamp[0] = 1'b0;
        if (w_clamp < (CFG_DATA_W+1)'(2)) begin
            w_clamp = (CFG_DATA_W+1)'(2);
        end
        h_clamp = ({1'b0, i_cfg_data} > (CFG_DATA_W+1)'(MAX_HEIGHT))
                ? (CFG_DATA_W+1)'(MAX_HEIGHT) : {1'b0, i_cfg_data};
        h_clamp[0] = 1'b0;
        if (h_clamp < (CFG_DATA_W+1)'(2)) begin
            h_clamp = (CFG_DATA_W+1)'(2);
        end
    end

    // Any write to a listed register restarts the picture
    always_comb begin
        cfg_restart = 1'b0;
        if (cfg_fire) begin
            unique case (i_cfg_index)
                REG_FORMAT, REG_WIDTH, REG_HEIGHT: cfg_restart = 1'b1;
                default:                           cfg_restart = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt    <= FMT_BGR24;
            r_width  <= WW'(RST_W);
            r_height <= HW'(RST_H);
        end else if (cfg_fire) begin
            unique case (i_cfg_index)
                REG_FORMAT: r_fmt    <= t_format'(i_cfg_data[1:0]);
                REG_WIDTH:  r_width  <= WW'(w_clamp);
                REG_HEIGHT: r_height <= HW'(h_clamp);
                default:    ;
            endcase
        end
    end

    // ---------------- input register ----------------
    logic                  r_s1_valid;
    logic [4*BYTE_W-1:0]   r_s1_data;
    logic [CW-1:0]         r_s1_col;
    logic [RW-1:0]         r_s1_row;
    logic                  r_s1_eop;
    logic                  n_s1_valid;
    logic                  emit_ready;
    logic                  in_fire;
    logic                  in_take;
    logic [CW-1:0]         pos_col;
    logic [RW-1:0]         pos_row;
    logic                  pos_eop;

    assign o_s_tready = !r_s1_valid || emit_ready;
    assign in_fire    = i_s_tvalid && o_s_tready;
    // Drop items of the reserved format: no writes, no advance
    assign in_take    = in_fire && (r_fmt != FMT_RSVD);

    rti_position #(
        .CW (CW),
        .RW (RW),
        .WW (WW),
        .HW (HW)
    ) u_position (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_restart (cfg_restart),
        .i_advance (in_take),
        .i_fmt     (r_fmt),
        .i_width   (r_width),
        .i_height  (r_height),
        .o_col     (pos_col),
        .o_row     (pos_row),
        .o_eop     (pos_eop)
    );

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (in_take) begin
            n_s1_valid = 1'b1;
        end else if (emit_ready) begin
            n_s1_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
        end
    end

    // Capture payload with the position it lands on
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_data <= i_s_tdata;
            r_s1_col  <= pos_col;
            r_s1_row  <= pos_row;
            r_s1_eop  <= pos_eop;
        end
    end

    // ---------------- conversion ----------------
    t_bundle calc_bundle;

    rti_calc #(
        .CW (CW),
        .RW (RW),
        .WW (WW),
        .HW (HW)
    ) u_calc (
        .i_fmt    (r_fmt),
        .i_width  (r_width),
        .i_height (r_height),
        .i_data   (r_s1_data),
        .i_col    (r_s1_col),
        .i_row    (r_s1_row),
        .i_eop    (r_s1_eop),
        .o_bundle (calc_bundle)
    );

    // ---------------- result register and output ----------------
    t_result out_res;
    logic    out_eop;

    rti_emit u_emit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (r_s1_valid),
        .i_bundle   (calc_bundle),
        .o_ready    (emit_ready),
        .i_m_tready (i_m_tready),
        .o_valid    (o_m_tvalid),
        .o_res      (out_res),
        .o_last     (o_m_tlast),
        .o_eop      (out_eop)
    );

    assign o_m_tdata = {out_res.value, out_res.addr};
    assign o_m_tuser = {out_eop, out_res.plane};

    // ---------------- assertions ----------------
    // Position never leaves the picture
    `ASSERT_PROP(a_pos_in_range, i_clk, i_rst_n, (WW'(pos_col) < r_width) && (HW'(pos_row) < r_height))
    // Chroma writes always close their item
    `ASSERT_IMPL(a_chroma_is_last, i_clk, i_rst_n, o_m_tvalid && (o_m_tuser[1:0] != PLANE_Y), o_m_tlast)
    // An item's writes continue back to back until the last one
    `ASSERT_PROP(a_item_continues, i_clk, i_rst_n, (o_m_tvalid && i_m_tready && !o_m_tlast) |=> o_m_tvalid)
    // A held input item keeps its payload
    `ASSERT_PROP(a_s1_holds, i_clk, i_rst_n, (r_s1_valid && !emit_ready) |=> (r_s1_valid && $stable(r_s1_data)))

endmodule
